>>> rtl/core/bpt_pkg.sv
package bpt_pkg;

    // Widths fixed by the register map and the result fields
    localparam int DEBOUNCE_W  = 16;
    localparam int LONG_W      = 16;
    localparam int SINCE_W     = 17;
    localparam int TICKS_W     = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LEVEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS = 2'd2;

    // Reset values of the configuration registers
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic                  EXPECTED_RESET = 1'b0;
    localparam logic [LONG_W-1:0]     LONG_RESET     = 16'd1000;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_ticks;
        logic                  expected_level;
        logic [LONG_W-1:0]     long_press_ticks;
    } t_cfg;

    // Press status produced for one tick
    typedef struct packed {
        logic               press_ended;
        logic [TICKS_W-1:0] press_ticks;
        logic               long_press;
    } t_press_res;

endpackage

>>> rtl/core/bpt_debounce.sv
module bpt_debounce (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic                              i_raw,
    input  logic [bpt_pkg::DEBOUNCE_W-1:0]    i_debounce_ticks,
    output logic                              o_stable
);

    localparam logic [bpt_pkg::SINCE_W-1:0] SINCE_MAX = '1;

    logic                         r_prev;
    logic                         r_stable;
    logic [bpt_pkg::SINCE_W-1:0]  r_since;
    logic [bpt_pkg::SINCE_W-1:0]  n_since;
    logic                         n_stable;

    // Count ticks since the raw level last changed, holding at the top.
    always_comb begin
        if (i_raw != r_prev) begin
            n_since = '0;
        end else if (r_since == SINCE_MAX) begin
            n_since = r_since;
        end else begin
            n_since = r_since + 1'b1;
        end
        n_stable = (n_since > bpt_pkg::SINCE_W'(i_debounce_ticks)) ? i_raw : r_stable;
    end

    assign o_stable = n_stable;

    // State advances once per tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= 1'b0;
            r_stable <= 1'b0;
            r_since  <= '0;
        end else if (i_step) begin
            r_prev   <= i_raw;
            r_stable <= n_stable;
            r_since  <= n_since;
        end
    end

endmodule

>>> rtl/core/bpt_press.sv
module bpt_press #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic                                i_stable,
    input  logic                                i_expected_level,
    input  logic [bpt_pkg::LONG_W-1:0]          i_long_press_ticks,
    output bpt_pkg::t_press_res                 o_res
);

    logic                  r_in_press;
    logic                  r_fired;
    logic [TIME_WIDTH-1:0] r_count;
    logic                  n_in_press;
    logic                  n_fired;
    logic [TIME_WIDTH-1:0] n_count;
    logic [TIME_WIDTH-1:0] count_inc;
    logic [TIME_WIDTH-1:0] long_ext;
    logic [63:0]           len_wide;
    logic                  pressed;

    assign pressed   = (i_stable == i_expected_level);
    assign long_ext  = TIME_WIDTH'(i_long_press_ticks);
    assign count_inc = (r_count == '1) ? r_count : r_count + 1'b1;
    assign len_wide  = 64'(count_inc);

    // Press phase: wait for a press, time it, flag a long press once, report its length at the end.
    always_comb begin
        n_in_press        = r_in_press;
        n_fired           = r_fired;
        n_count           = r_count;
        o_res.press_ended = 1'b0;
        o_res.press_ticks = '0;
        o_res.long_press  = 1'b0;
        if (!r_in_press) begin
            if (pressed) begin
                n_in_press = 1'b1;
                n_count    = '0;
                n_fired    = 1'b0;
                // A zero long-press setting fires on the start tick.
                if (i_long_press_ticks == '0) begin
                    o_res.long_press = 1'b1;
                    n_fired          = 1'b1;
                end
            end
        end else if (pressed) begin
            n_count = count_inc;
            if (!r_fired && (count_inc >= long_ext)) begin
                o_res.long_press = 1'b1;
                n_fired          = 1'b1;
            end
        end else begin
            o_res.press_ended = 1'b1;
            o_res.press_ticks = (len_wide[63:bpt_pkg::TICKS_W] != '0) ? '1 :
                                len_wide[bpt_pkg::TICKS_W-1:0];
            n_in_press        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_press <= 1'b0;
            r_fired    <= 1'b0;
            r_count    <= '0;
        end else if (i_step) begin
            r_in_press <= n_in_press;
            r_fired    <= n_fired;
            r_count    <= n_count;
        end
    end

endmodule

>>> rtl/core/debounced_button_press_timer_unit.sv
// Button debounce and press timer.
// Input channel: one raw pin sample per beat (i_valid / o_ready), one beat
// per millisecond tick. Output channel: one result beat per input beat
// (o_valid / i_ready) with the debounced level, a press-ended flag with the
// saturated press length, and a one-time long-press flag.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 debounce ticks, 1 expected level, 2 long-press ticks); index 3 is
// ignored. Write only while no beat is in flight.
// A sample lands in the input register, then the debounce and press logic
// update state and fill the result register.
// Throughput is one beat per cycle while the receiver takes results; the
// state update is the only loop.
// Reset (synchronous, active low) empties both registers, clears all state
// and restores the configuration defaults 50 / 0 / 1000.
// When the receiver stalls, the result register holds, the input register
// holds one more sample, and o_ready then drops until the result is taken.
module debounced_button_press_timer_unit #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_raw_level,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_debounced_level,
    output logic                               o_press_ended,
    output logic [bpt_pkg::TICKS_W-1:0]        o_press_ticks,
    output logic                               o_long_press,
    input  logic                               i_cfg_we,
    input  logic [bpt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bpt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    bpt_pkg::t_cfg        r_cfg;
    logic                 r_in_valid;
    logic                 r_in_raw;
    logic                 r_out_valid;
    logic                 r_out_level;
    bpt_pkg::t_press_res  r_out_res;
    logic                 advance;
    logic                 stable;
    bpt_pkg::t_press_res  press_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= bpt_pkg::DEBOUNCE_RESET;
            r_cfg.expected_level   <= bpt_pkg::EXPECTED_RESET;
            r_cfg.long_press_ticks <= bpt_pkg::LONG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bpt_pkg::CFG_DEBOUNCE_TICKS: begin
                    r_cfg.debounce_ticks <= i_cfg_data;
                end
                bpt_pkg::CFG_EXPECTED_LEVEL: begin
                    r_cfg.expected_level <= i_cfg_data[0];
                end
                bpt_pkg::CFG_LONG_PRESS_TICKS: begin
                    r_cfg.long_press_ticks <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // The input register moves on when the result register is free or drains.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_raw <= i_raw_level;
        end
    end

    bpt_debounce u_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (advance),
        .i_raw            (r_in_raw),
        .i_debounce_ticks (r_cfg.debounce_ticks),
        .o_stable         (stable)
    );

    bpt_press #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_press (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (advance),
        .i_stable           (stable),
        .i_expected_level   (r_cfg.expected_level),
        .i_long_press_ticks (r_cfg.long_press_ticks),
        .o_res              (press_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_level <= stable;
            r_out_res   <= press_res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_debounced_level = r_out_level;
    assign o_press_ended     = r_out_res.press_ended;
    assign o_press_ticks     = r_out_res.press_ticks;
    assign o_long_press      = r_out_res.long_press;

    // A press cannot end and reach the long-press mark on the same tick.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_press_ended && o_long_press))
        else $error("press end and long press on the same beat");

    // The press length is zero unless a press ended.
    a_ticks_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_press_ended) |-> (o_press_ticks == '0))
        else $error("press length set without a press end");

    // Both registers full and the receiver stalled: no new sample is taken.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_ready) |-> !o_ready)
        else $error("sample taken while the pipeline is full");

    // A result beat follows a sample that was held in the input register.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result without a sample");

endmodule

>>> sim/debounced_button_press_timer_unit_test.sv
module debounced_button_press_timer_unit_test;

    localparam int TIME_W        = 32;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_COUNT   = 15;
    localparam int PHASE_SAMPLES = 120;

    // The register map leaves index 3 unused; writes to it must be ignored.
    localparam logic [bpt_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    localparam logic [bpt_pkg::SINCE_W-1:0] SINCE_MAX  = '1;
    localparam logic [TIME_W-1:0]           PRESS_MAX  = '1;
    localparam logic [bpt_pkg::TICKS_W-1:0] TICKS_MAX  = '1;

    typedef struct packed {
        logic                        debounced_level;
        logic                        press_ended;
        logic [bpt_pkg::TICKS_W-1:0] press_ticks;
        logic                        long_press;
    } t_tick_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic                           i_raw_level;
    logic                           o_valid;
    logic                           i_ready;
    logic                           o_debounced_level;
    logic                           o_press_ended;
    logic [bpt_pkg::TICKS_W-1:0]    o_press_ticks;
    logic                           o_long_press;
    logic                           i_cfg_we;
    logic [bpt_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [bpt_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // Register copies, starting from the reset values.
    logic [bpt_pkg::DEBOUNCE_W-1:0] cfg_debounce = bpt_pkg::DEBOUNCE_RESET;
    logic                           cfg_expected = bpt_pkg::EXPECTED_RESET;
    logic [bpt_pkg::LONG_W-1:0]     cfg_long     = bpt_pkg::LONG_RESET;

    // Debounce and press state, all zero after reset.
    logic                        prev_raw     = 1'b0;
    logic                        stable_level = 1'b0;
    logic [bpt_pkg::SINCE_W-1:0] since_change = '0;
    logic                        in_press     = 1'b0;
    logic [TIME_W-1:0]           press_count  = '0;
    logic                        long_fired   = 1'b0;

    t_tick_result tick_results_due[$];
    int unsigned  mismatch_count   = 0;
    int unsigned  quiet_cycles     = 0;
    int unsigned  burst_left       = 0;
    int unsigned  ready_hold_left  = 0;

    debounced_button_press_timer_unit #(
        .TIME_WIDTH(TIME_W)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_raw_level       (i_raw_level),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_debounced_level (o_debounced_level),
        .o_press_ended     (o_press_ended),
        .o_press_ticks     (o_press_ticks),
        .o_long_press      (o_long_press),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Advances the debounce and press state by one tick and returns its result.
    function automatic t_tick_result predict_tick(input logic raw);
        t_tick_result      result;
        logic [TIME_W-1:0] span;
        result = '0;
        if (raw != prev_raw) begin
            since_change = '0;
        end else if (since_change != SINCE_MAX) begin
            since_change = since_change + 1'b1;
        end
        if (since_change > {1'b0, cfg_debounce}) begin
            stable_level = raw;
        end
        prev_raw = raw;

        if (!in_press) begin
            if (stable_level == cfg_expected) begin
                in_press    = 1'b1;
                press_count = '0;
                long_fired  = 1'b0;
                // A zero long-press setting fires on the start tick itself.
                if (cfg_long == '0) begin
                    result.long_press = 1'b1;
                    long_fired        = 1'b1;
                end
            end
        end else if (stable_level == cfg_expected) begin
            if (press_count != PRESS_MAX) begin
                press_count = press_count + 1'b1;
            end
            if (!long_fired && press_count >= cfg_long) begin
                result.long_press = 1'b1;
                long_fired        = 1'b1;
            end
        end else begin
            // The reported length counts the end tick too, saturating.
            span = (press_count == PRESS_MAX) ? PRESS_MAX : press_count + 1'b1;
            result.press_ended = 1'b1;
            result.press_ticks = (span > TICKS_MAX) ? TICKS_MAX : bpt_pkg::TICKS_W'(span);
            in_press = 1'b0;
        end
        result.debounced_level = stable_level;
        return result;
    endfunction

    // Writes one register while the block is idle and mirrors it locally.
    task automatic write_reg(input logic [bpt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bpt_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            bpt_pkg::CFG_DEBOUNCE_TICKS:   cfg_debounce = data;
            bpt_pkg::CFG_EXPECTED_LEVEL:   cfg_expected = data[0];
            bpt_pkg::CFG_LONG_PRESS_TICKS: cfg_long     = data;
            default: ;
        endcase
    endtask

    // Offers one sample beat, records its expected result once accepted, and
    // inserts a random gap when the current burst runs out.
    task automatic send_sample(input logic raw);
        int unsigned gap;
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_raw_level <= raw;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tick_results_due.push_back(predict_tick(raw));

        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // Stops offering and waits until every expected result beat has arrived.
    task automatic drain;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tick_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // With reset defaults the released level counts as pressed at once.
    task automatic test_reset_defaults;
        send_sample(1'b0);
        send_sample(1'b0);
        send_sample(1'b1);
        send_sample(1'b1);
    endtask

    // Zero debounce and zero long-press; the expected level flips mid-press.
    task automatic test_zero_settings;
        drain();
        write_reg(bpt_pkg::CFG_DEBOUNCE_TICKS, '0);
        write_reg(bpt_pkg::CFG_EXPECTED_LEVEL, 16'h0001);
        write_reg(bpt_pkg::CFG_LONG_PRESS_TICKS, '0);
        send_sample(1'b1);
        send_sample(1'b1);
        send_sample(1'b1);
        send_sample(1'b0);
        send_sample(1'b0);
        send_sample(1'b1);
    endtask

    // A one-tick glitch is filtered, then a press fires long-press and ends.
    task automatic test_glitch_filter;
        drain();
        write_reg(bpt_pkg::CFG_DEBOUNCE_TICKS, 16'd3);
        write_reg(bpt_pkg::CFG_LONG_PRESS_TICKS, 16'd2);
        send_sample(1'b1);
        send_sample(1'b0);
        repeat (8) send_sample(1'b1);
        repeat (5) send_sample(1'b0);
    endtask

    task automatic test_unused_index;
        drain();
        write_reg(CFG_UNUSED_IDX, '1);
        send_sample(1'b0);
        send_sample(1'b0);
    endtask

    // Largest settings: debounce and long-press both at their maximum, so a
    // steady hold of 40 samples is not accepted, then a zero debounce releases it.
    task automatic test_longest_settings;
        drain();
        write_reg(bpt_pkg::CFG_DEBOUNCE_TICKS, '1);
        write_reg(bpt_pkg::CFG_LONG_PRESS_TICKS, '1);
        write_reg(bpt_pkg::CFG_EXPECTED_LEVEL, 16'hFFFF);
        repeat (40) send_sample(1'b1);
        drain();
        write_reg(bpt_pkg::CFG_DEBOUNCE_TICKS, '0);
        repeat (3) send_sample(1'b0);
    endtask

    // The receiver holds off for a long stretch while samples keep coming,
    // so the block fills up and drops its input ready.
    task automatic test_receiver_hold;
        drain();
        ready_hold_left = 300;
        repeat (60) send_sample(1'(($urandom_range(7) == 0) ? 1 : 0) ^ i_raw_level);
    endtask

    // Phases of random settings, each with runs of random length around the
    // debounce setting, so most runs pass the filter and some are glitches.
    task automatic test_random_phases;
        int unsigned sent;
        int unsigned span;
        logic        level;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            drain();
            if ($urandom_range(2) != 0) begin
                case ($urandom_range(5))
                    0:       write_reg(bpt_pkg::CFG_DEBOUNCE_TICKS, '0);
                    1:       write_reg(bpt_pkg::CFG_DEBOUNCE_TICKS, 16'd1);
                    5:       write_reg(bpt_pkg::CFG_DEBOUNCE_TICKS,
                                       16'($urandom_range(13, 40)));
                    default: write_reg(bpt_pkg::CFG_DEBOUNCE_TICKS,
                                       16'($urandom_range(2, 12)));
                endcase
            end
            if ($urandom_range(2) != 0) begin
                case ($urandom_range(5))
                    0:       write_reg(bpt_pkg::CFG_LONG_PRESS_TICKS, '0);
                    1:       write_reg(bpt_pkg::CFG_LONG_PRESS_TICKS, 16'd1);
                    4:       write_reg(bpt_pkg::CFG_LONG_PRESS_TICKS,
                                       16'($urandom_range(41, 200)));
                    5:       write_reg(bpt_pkg::CFG_LONG_PRESS_TICKS,
                                       16'($urandom_range(0, 65535)));
                    default: write_reg(bpt_pkg::CFG_LONG_PRESS_TICKS,
                                       16'($urandom_range(2, 40)));
                endcase
            end
            write_reg(bpt_pkg::CFG_EXPECTED_LEVEL, 16'($urandom_range(0, 65535)));
            if ($urandom_range(5) == 0) begin
                write_reg(CFG_UNUSED_IDX, 16'($urandom_range(0, 65535)));
            end

            sent  = 0;
            level = 1'($urandom_range(1));
            while (sent < PHASE_SAMPLES) begin
                if ($urandom_range(4) == 0) begin
                    span = $urandom_range(1, cfg_debounce + 1);
                end else begin
                    span = $urandom_range(cfg_debounce + 1, cfg_debounce + 25);
                end
                for (int k = 0; k < span && sent < PHASE_SAMPLES; k++) begin
                    send_sample(level);
                    sent++;
                end
                level = ~level;
            end
        end
    endtask

    // Receiver: segments of random stall density, plus the requested hold-off.
    initial begin
        int unsigned seg_left;
        int unsigned stall_pct;
        seg_left  = 0;
        stall_pct = 0;
        i_ready   = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (ready_hold_left != 0) begin
                i_ready <= 1'b0;
                ready_hold_left--;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(4, 80);
                    case ($urandom_range(4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 20;
                        3:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                seg_left--;
                i_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Compares each accepted result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_tick_result due;
        if (i_rst_n && o_valid && i_ready) begin
            if (tick_results_due.size() == 0) begin
                $error("result beat with no expectation waiting");
                mismatch_count++;
            end else begin
                due = tick_results_due.pop_front();
                if (o_debounced_level !== due.debounced_level) begin
                    $error("debounced_level: expected %0d, actual %0d",
                           due.debounced_level, o_debounced_level);
                    mismatch_count++;
                end
                if (o_press_ended !== due.press_ended) begin
                    $error("press_ended: expected %0d, actual %0d",
                           due.press_ended, o_press_ended);
                    mismatch_count++;
                end
                if (o_press_ticks !== due.press_ticks) begin
                    $error("press_ticks: expected %0d, actual %0d",
                           due.press_ticks, o_press_ticks);
                    mismatch_count++;
                end
                if (o_long_press !== due.long_press) begin
                    $error("long_press: expected %0d, actual %0d",
                           due.long_press, o_long_press);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("debounced_button_press_timer_unit_test failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_raw_level = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = bpt_pkg::CFG_DEBOUNCE_TICKS;
        i_cfg_data  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_settings();
        test_glitch_filter();
        test_unused_index();
        test_longest_settings();
        test_receiver_hold();
        test_random_phases();
        drain();
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0 && tick_results_due.size() == 0) begin
            $display("debounced_button_press_timer_unit_test passed");
        end else begin
            $display("debounced_button_press_timer_unit_test failed");
        end
        $finish;
    end

endmodule
